[src/psc_pkg.sv]
// ----------------------------------------------------------------------------
// psc_pkg
// Shared types and constants for the pressure sensor command slave: bus
// operation codes, command bytes, register indexes and reset values.
// ----------------------------------------------------------------------------
package psc_pkg;

  typedef enum logic [1:0] {
    OP_WRITE_BYTE  = 2'd0,
    OP_READ_BYTE   = 2'd1,
    OP_START_READ  = 2'd2,
    OP_START_WRITE = 2'd3
  } op_t;

  localparam logic [7:0] CMD_RESET_BYTE       = 8'h1e;
  localparam logic [7:0] CMD_CONV_PRESSURE    = 8'h40;
  localparam logic [7:0] CMD_CONV_TEMPERATURE = 8'h50;
  localparam logic [7:0] CMD_PROM_BASE        = 8'ha0;
  localparam logic [7:0] CMD_GROUP_MASK       = 8'hf0;
  localparam logic [7:0] CMD_ADC_BYTE         = 8'h00;

  localparam int CALIB_WORDS = 6;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;

  localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_RAW    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TEMPERATURE_RAW = 3'd7;

  localparam logic [15:0] CALIB_RESET [CALIB_WORDS] =
    '{16'd34982, 16'd36352, 16'd20328, 16'd22354, 16'd26646, 16'd26146};
  localparam logic [23:0] PRESSURE_RESET    = 24'd9085466;
  localparam logic [23:0] TEMPERATURE_RESET = 24'd8569150;

  localparam logic [2:0] PROM_ADDR_FIRST = 3'd1;
  localparam logic [2:0] PROM_ADDR_LAST  = 3'd6;

  typedef struct packed {
    logic [CALIB_WORDS-1:0][15:0] calib;
    logic [23:0]                  pressure_raw;
    logic [23:0]                  temperature_raw;
  } cfg_t;

endpackage

[src/psc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// psc_cfg_regs
// Configuration register file: calibration words and raw conversion values,
// written one register per configuration transaction.
// ----------------------------------------------------------------------------
module psc_cfg_regs import psc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CALIB_WORDS; i++) begin
        regs.calib[i] <= CALIB_RESET[i];
      end
      regs.pressure_raw    <= PRESSURE_RESET;
      regs.temperature_raw <= TEMPERATURE_RESET;
    end else if (wr_en) begin
      if (wr_index == REG_PRESSURE_RAW) begin
        regs.pressure_raw <= wr_data;
      end else if (wr_index == REG_TEMPERATURE_RAW) begin
        regs.temperature_raw <= wr_data;
      end else begin
        regs.calib[wr_index] <= wr_data[15:0];
      end
    end
  end

  assign cfg = regs;

endmodule

[src/psc_cmd_core.sv]
// ----------------------------------------------------------------------------
// psc_cmd_core
// Command decoder and response buffer. Updates the latched reading, response
// bytes, length and read position for each accepted transaction and forms the
// returned byte in the same cycle.
// ----------------------------------------------------------------------------
module psc_cmd_core import psc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       step_en,
  input  op_t        op,
  input  logic [7:0] data_in,
  input  cfg_t       cfg,
  output logic [7:0] result
);

  logic [23:0]     latched_reading;
  logic [2:0][7:0] response_bytes;
  logic [1:0]      response_length;
  logic [1:0]      read_position;

  logic [23:0]     latched_reading_next;
  logic [2:0][7:0] response_bytes_next;
  logic [1:0]      response_length_next;
  logic [1:0]      read_position_next;

  logic [7:0]  group;
  logic [2:0]  prom_addr;
  logic [15:0] prom_word;
  logic        can_read;
  logic [7:0]  cur_byte;

  assign group     = data_in & CMD_GROUP_MASK;
  assign prom_addr = data_in[3:1];
  assign can_read  = read_position < response_length;

  always_comb begin
    prom_word = 16'd0;
    if (prom_addr >= PROM_ADDR_FIRST && prom_addr <= PROM_ADDR_LAST) begin
      prom_word = cfg.calib[prom_addr - PROM_ADDR_FIRST];
    end
  end

  always_comb begin
    case (read_position)
      2'd0:    cur_byte = response_bytes[0];
      2'd1:    cur_byte = response_bytes[1];
      2'd2:    cur_byte = response_bytes[2];
      default: cur_byte = 8'd0;
    endcase
  end

  always_comb begin
    latched_reading_next = latched_reading;
    response_bytes_next  = response_bytes;
    response_length_next = response_length;
    read_position_next   = read_position;
    result               = 8'd0;
    unique case (op)
      OP_WRITE_BYTE: begin
        if (data_in == CMD_RESET_BYTE || group == CMD_CONV_PRESSURE) begin
          latched_reading_next = cfg.pressure_raw;
          response_length_next = 2'd0;
        end else if (group == CMD_CONV_TEMPERATURE) begin
          latched_reading_next = cfg.temperature_raw;
          response_length_next = 2'd0;
        end else if (data_in == CMD_ADC_BYTE) begin
          response_bytes_next  = {latched_reading[7:0], latched_reading[15:8],
                                  latched_reading[23:16]};
          response_length_next = 2'd3;
          read_position_next   = 2'd0;
        end else if (group == CMD_PROM_BASE) begin
          response_bytes_next  = {response_bytes[2], prom_word[7:0], prom_word[15:8]};
          response_length_next = 2'd2;
          read_position_next   = 2'd0;
        end
      end
      OP_READ_BYTE: begin
        if (can_read) begin
          result             = cur_byte;
          read_position_next = read_position + 2'd1;
        end
      end
      OP_START_READ: begin
        read_position_next = 2'd0;
      end
      OP_START_WRITE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      latched_reading <= PRESSURE_RESET;
      response_bytes  <= '0;
      response_length <= 2'd0;
      read_position   <= 2'd0;
    end else if (step_en) begin
      latched_reading <= latched_reading_next;
      response_bytes  <= response_bytes_next;
      response_length <= response_length_next;
      read_position   <= read_position_next;
    end
  end

  // a response is never one byte long
  assert property (@(posedge clk) disable iff (rst) response_length != 2'd1)
    else $error("response length of one");

  // adc read rewinds and loads three bytes
  assert property (@(posedge clk) disable iff (rst)
    step_en && op == OP_WRITE_BYTE && data_in == CMD_ADC_BYTE
    |=> response_length == 2'd3 && read_position == 2'd0)
    else $error("adc read did not load response");

  // a nonzero byte only comes from a read inside the response
  assert property (@(posedge clk) disable iff (rst)
    result != 8'd0 |-> op == OP_READ_BYTE && can_read)
    else $error("byte returned outside a read");

endmodule

[src/psc_out_stage.sv]
// ----------------------------------------------------------------------------
// psc_out_stage
// Two-entry output buffer (head plus skid) holding returned bytes, so the
// input ready depends only on registered state.
// ----------------------------------------------------------------------------
module psc_out_stage import psc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic [7:0] push_data,
  output logic       space,
  output logic       head_valid,
  input  logic       pop,
  output logic [7:0] head_data
);

  logic       valid0;
  logic       valid1;
  logic [7:0] data0;
  logic [7:0] data1;

  assign space      = !valid1;
  assign head_valid = valid0;
  assign head_data  = data0;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid0 <= 1'b0;
      valid1 <= 1'b0;
    end else if (valid1) begin
      if (pop) begin
        valid1 <= 1'b0;
      end
    end else if (valid0) begin
      if (push && !pop) begin
        valid1 <= 1'b1;
      end else if (!push && pop) begin
        valid0 <= 1'b0;
      end
    end else if (push) begin
      valid0 <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (valid1) begin
      if (pop) begin
        data0 <= data1;
      end
    end else if (valid0) begin
      if (push && pop) begin
        data0 <= push_data;
      end else if (push) begin
        data1 <= push_data;
      end
    end else if (push) begin
      data0 <= push_data;
    end
  end

  // skid entry only holds data behind a full head
  assert property (@(posedge clk) disable iff (rst) valid1 |-> valid0)
    else $error("skid entry without head entry");

  // a push into a stalled head lands in the skid entry
  assert property (@(posedge clk) disable iff (rst)
    push && valid0 && !pop |=> valid1 && data1 == $past(push_data))
    else $error("stalled push lost");

  // draining the skid entry moves it to the head
  assert property (@(posedge clk) disable iff (rst)
    valid1 && pop |=> valid0 && !valid1 && data0 == $past(data1))
    else $error("skid entry not forwarded");

endmodule

[src/pressure_sensor_command_slave.sv]
// ----------------------------------------------------------------------------
// pressure_sensor_command_slave
// Byte-level command slave of a pressure sensor: decodes command bytes,
// latches conversion values and returns ADC and PROM response bytes.
//
//   channel   signals                        direction
//   input     in_valid/in_ready op data_in   to block
//   output    out_valid/out_ready read_data  from block
//   config    cfg_valid/cfg_ready cfg_index  to block
//             cfg_data
//
// one transaction per cycle while in_ready is high; the returned byte is
// formed combinationally and registered in the output buffer. the two-entry
// output buffer keeps accepting while a byte waits; in_ready falls only
// when both entries are full. synchronous reset restores all registers but
// the output buffer data; config writes are always ready.
// ----------------------------------------------------------------------------
module pressure_sensor_command_slave import psc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            op,
  input  logic [7:0]            data_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            read_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t       cfg;
  logic       accept;
  logic       space;
  logic [7:0] result;

  assign cfg_ready = 1'b1;
  assign in_ready  = space;
  assign accept    = in_valid && space;

  psc_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  psc_cmd_core u_cmd_core (
    .clk     (clk),
    .rst     (rst),
    .step_en (accept),
    .op      (op_t'(op)),
    .data_in (data_in),
    .cfg     (cfg),
    .result  (result)
  );

  psc_out_stage u_out_stage (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_data  (result),
    .space      (space),
    .head_valid (out_valid),
    .pop        (out_ready),
    .head_data  (read_data)
  );

endmodule

[dv/tb_pressure_sensor_command_slave.sv]
// ----------------------------------------------------------------------------
// tb_pressure_sensor_command_slave
// Self-checking bench for the pressure sensor command slave. A short table of
// bus events (reads after reset, ADC and PROM responses, exhausted and emptied
// responses, ignored bytes) is followed by six phases of random command
// sequences, each under its own set of calibration and conversion registers,
// with the zero and all-ones extremes among them. Every returned byte is
// compared in order against its table value or a local model of the slave,
// while both channels stall at random except in the last two phases.
// ----------------------------------------------------------------------------
module tb_pressure_sensor_command_slave;
  import psc_pkg::*;

  localparam int CYCLE_LIMIT = 100000;
  localparam int PHASE_ITEMS = 67;
  localparam int ROWS        = 29;

  typedef struct packed {
    op_t        o;
    logic [7:0] d;
    logic       chk;
    logic [7:0] b;
  } step_row_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  logic [1:0]            op        = OP_START_WRITE;
  logic [7:0]            data_in   = 8'h00;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [7:0]            read_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // local copy of the slave
  logic [15:0] cal_word [CALIB_WORDS];
  logic [23:0] press_reg;
  logic [23:0] temp_reg;
  logic [23:0] held_reading;
  logic [7:0]  resp_byte [3];
  logic [1:0]  resp_count;
  logic [1:0]  read_ptr;

  logic [7:0] expected_bytes [$];
  int         error_count   = 0;
  int         items_sent    = 0;
  int         cycles        = 0;
  int         send_idle_pct = 35;
  int         recv_idle_pct = 50;

  step_row_t directed_rows [ROWS] = '{
    '{OP_READ_BYTE,   8'h00,          1'b1, 8'h00},
    '{OP_START_READ,  8'h00,          1'b1, 8'h00},
    '{OP_WRITE_BYTE,  CMD_ADC_BYTE,   1'b1, 8'h00},
    '{OP_READ_BYTE,   8'h00,          1'b1, 8'h8a},
    '{OP_READ_BYTE,   8'h00,          1'b1, 8'ha2},
    '{OP_READ_BYTE,   8'h00,          1'b1, 8'h1a},
    '{OP_READ_BYTE,   8'h00,          1'b1, 8'h00},
    '{OP_START_READ,  8'h00,          1'b1, 8'h00},
    '{OP_READ_BYTE,   8'h00,          1'b1, 8'h8a},
    '{OP_WRITE_BYTE,  8'ha2,          1'b1, 8'h00},
    '{OP_READ_BYTE,   8'h00,          1'b1, 8'h88},
    '{OP_READ_BYTE,   8'h00,          1'b1, 8'ha6},
    '{OP_WRITE_BYTE,  8'ha0,          1'b1, 8'h00},
    '{OP_READ_BYTE,   8'h00,          1'b1, 8'h00},
    '{OP_WRITE_BYTE,  8'haf,          1'b1, 8'h00},
    '{OP_READ_BYTE,   8'h00,          1'b1, 8'h00},
    '{OP_WRITE_BYTE,  8'ha3,          1'b1, 8'h00},
    '{OP_READ_BYTE,   8'h00,          1'b1, 8'h88},
    '{OP_WRITE_BYTE,  8'h5f,          1'b1, 8'h00},
    '{OP_WRITE_BYTE,  CMD_ADC_BYTE,   1'b1, 8'h00},
    '{OP_READ_BYTE,   8'h00,          1'b1, 8'h82},
    '{OP_WRITE_BYTE,  CMD_RESET_BYTE, 1'b1, 8'h00},
    '{OP_READ_BYTE,   8'h00,          1'b1, 8'h00},
    '{OP_START_WRITE, 8'hff,          1'b1, 8'h00},
    '{OP_WRITE_BYTE,  8'hff,          1'b1, 8'h00},
    '{OP_WRITE_BYTE,  8'h4a,          1'b1, 8'h00},
    '{OP_WRITE_BYTE,  CMD_ADC_BYTE,   1'b1, 8'h00},
    '{OP_READ_BYTE,   8'h00,          1'b1, 8'h8a},
    '{OP_READ_BYTE,   8'hff,          1'b0, 8'h00}
  };

  pressure_sensor_command_slave uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .data_in   (data_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .read_data (read_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_pressure_sensor_command_slave: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t: read_data expected none actual %02h", $time, read_data);
        error_count++;
      end else begin
        if (read_data !== expected_bytes[0]) begin
          $display("%0t: read_data expected %02h actual %02h", $time,
                   expected_bytes[0], read_data);
          error_count++;
        end
        void'(expected_bytes.pop_front());
      end
    end
  end

  function automatic logic [7:0] predict_read_byte(op_t o, logic [7:0] d);
    logic [7:0]  rb;
    logic [2:0]  addr;
    logic [15:0] w;
    rb = 8'h00;
    case (o)
      OP_WRITE_BYTE: begin
        if (d == CMD_RESET_BYTE || (d & CMD_GROUP_MASK) == CMD_CONV_PRESSURE) begin
          held_reading = press_reg;
          resp_count   = 2'd0;
        end else if ((d & CMD_GROUP_MASK) == CMD_CONV_TEMPERATURE) begin
          held_reading = temp_reg;
          resp_count   = 2'd0;
        end else if (d == CMD_ADC_BYTE) begin
          resp_byte[0] = held_reading[23:16];
          resp_byte[1] = held_reading[15:8];
          resp_byte[2] = held_reading[7:0];
          resp_count   = 2'd3;
          read_ptr     = 2'd0;
        end else if ((d & CMD_GROUP_MASK) == CMD_PROM_BASE) begin
          addr = d[3:1];
          w = (addr >= PROM_ADDR_FIRST && addr <= PROM_ADDR_LAST) ?
              cal_word[addr - PROM_ADDR_FIRST] : 16'h0000;
          resp_byte[0] = w[15:8];
          resp_byte[1] = w[7:0];
          resp_count   = 2'd2;
          read_ptr     = 2'd0;
        end
      end
      OP_READ_BYTE: begin
        if (read_ptr < resp_count && read_ptr < 2'd3) begin
          rb       = resp_byte[read_ptr];
          read_ptr = read_ptr + 2'd1;
        end
      end
      OP_START_READ: read_ptr = 2'd0;
      default: ;
    endcase
    return rb;
  endfunction

  task automatic send_item(input op_t o, input logic [7:0] d,
                           input logic chk = 1'b0, input logic [7:0] b = 8'h00);
    logic [7:0] pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= o;
    data_in  <= d;
    do @(posedge clk); while (!in_ready);
    pred = predict_read_byte(o, d);
    expected_bytes.push_back(chk ? b : pred);
    items_sent++;
  endtask

  task automatic send_reads(input int n);
    for (int i = 0; i < n; i++) begin
      send_item(OP_READ_BYTE, 8'($urandom_range(255)));
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_PRESSURE_RAW) press_reg = val;
    else if (idx == REG_TEMPERATURE_RAW) temp_reg = val;
    else cal_word[idx] = val[15:0];
  endtask

  function automatic logic [7:0] random_convert();
    case ($urandom_range(2))
      0: return CMD_RESET_BYTE;
      1: return CMD_CONV_PRESSURE | 8'($urandom_range(15));
      default: return CMD_CONV_TEMPERATURE | 8'($urandom_range(15));
    endcase
  endfunction

  task automatic random_sequence();
    int r;
    r = $urandom_range(99);
    if (r < 40) begin
      if ($urandom_range(1)) send_item(OP_WRITE_BYTE, random_convert());
      send_item(OP_WRITE_BYTE, CMD_ADC_BYTE);
      if ($urandom_range(3) == 0) send_item(OP_START_READ, 8'($urandom_range(255)));
      send_reads($urandom_range(4));
    end else if (r < 75) begin
      send_item(OP_WRITE_BYTE, CMD_PROM_BASE | 8'($urandom_range(15)));
      if ($urandom_range(3) == 0) send_item(OP_START_READ, 8'($urandom_range(255)));
      send_reads($urandom_range(3));
    end else if (r < 85) begin
      send_item(OP_WRITE_BYTE, random_convert());
      send_reads($urandom_range(2));
    end else begin
      send_item(op_t'($urandom_range(3)), 8'($urandom_range(255)));
    end
  endtask

  initial begin
    logic [23:0] val;
    int          target;
    for (int i = 0; i < CALIB_WORDS; i++) cal_word[i] = CALIB_RESET[i];
    press_reg    = PRESSURE_RESET;
    temp_reg     = TEMPERATURE_RESET;
    held_reading = PRESSURE_RESET;
    for (int i = 0; i < 3; i++) resp_byte[i] = 8'h00;
    resp_count = 2'd0;
    read_ptr   = 2'd0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].o, directed_rows[i].d,
                directed_rows[i].chk, directed_rows[i].b);
    end

    for (int ph = 0; ph < 6; ph++) begin
      case (ph / 2)
        0: begin send_idle_pct = 35; recv_idle_pct = 50; end
        1: begin send_idle_pct = 50; recv_idle_pct = 35; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      // latch a reading under the old registers first
      send_item(OP_WRITE_BYTE, random_convert());
      wait_drained();
      for (int i = 0; i < 8; i++) begin
        if (ph == 0) val = 24'h000000;
        else if (ph == 1) val = 24'hffffff;
        else val = 24'($urandom);
        write_reg(CFG_IDX_W'(i), val);
      end
      cfg_valid <= 1'b0;
      @(posedge clk);
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) random_sequence();
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_pressure_sensor_command_slave: clean");
    end else begin
      $display("tb_pressure_sensor_command_slave: errors");
    end
    $finish;
  end

endmodule

[sim.f]
src/psc_pkg.sv
src/psc_cfg_regs.sv
src/psc_cmd_core.sv
src/psc_out_stage.sv
src/pressure_sensor_command_slave.sv
dv/tb_pressure_sensor_command_slave.sv
